>>> hdl/plm_pkg.sv
// Shared result codes and controller/datapath handshake types for the lock manager.
package plm_pkg;

  localparam logic [1:0] KIND_REPLY    = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_BAD_INDEX = 2'd2;
  localparam logic [1:0] ERR_IDLE_DONE = 2'd3;

  localparam int CLIENT_W = 8;
  localparam int VALUE_W  = 32;
  localparam int ENTRY_W  = CLIENT_W + VALUE_W;

  typedef struct packed {
    logic capture;      // latch the accepted request
    logic exec;         // evaluate, update queues, load first result
    logic load_second;  // load the dispatch read from the queue store
  } plm_cmd_t;

  typedef struct packed {
    logic has_first;
    logic has_second;
  } plm_status_t;

endpackage

>>> hdl/per_resource_fifo_lock_manager.sv
// Top level of the per-resource FIFO lock manager.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | in_valid/in_ready  | func, requester, resource_index, payload
//  output   | out_valid/out_ready| kind, error_code, dest_client, dest_resource,
//           |                    | result_value, last
//
// A request that yields at most one result is captured, then evaluated with the
// queue store write or read. A completion that frees a queued request yields a
// second result in the cycle after the reply is taken, read from the single-port
// queue store. Reset clears pointers, counts and busy flags at once; the queue
// store itself needs no clearing. A stalled output holds the next request off
// only while the result register cannot drain.
module per_resource_fifo_lock_manager #(
  parameter int NUM_RESOURCES = 3,
  parameter int QUEUE_DEPTH   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [7:0]         requester,
  input  logic [1:0]         resource_index,
  input  logic signed [31:0] payload,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [1:0]         error_code,
  output logic [7:0]         dest_client,
  output logic [1:0]         dest_resource,
  output logic signed [31:0] result_value,
  output logic               last
);
  import plm_pkg::*;

  plm_cmd_t    cmd;
  plm_status_t st;

  plm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  plm_datapath #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .func           (func),
    .requester      (requester),
    .resource_index (resource_index),
    .payload        (payload),
    .kind           (kind),
    .error_code     (error_code),
    .dest_client    (dest_client),
    .dest_resource  (dest_resource),
    .result_value   (result_value),
    .last           (last)
  );

endmodule

>>> hdl/plm_datapath.sv
// Queue store, per-resource pointers and busy flags, and the result register.
module plm_datapath #(
  parameter int NUM_RESOURCES = 3,
  parameter int QUEUE_DEPTH   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  plm_pkg::plm_cmd_t    cmd,
  output plm_pkg::plm_status_t st,
  input  logic                 func,
  input  logic [7:0]           requester,
  input  logic [1:0]           resource_index,
  input  logic signed [31:0]   payload,
  output logic [1:0]           kind,
  output logic [1:0]           error_code,
  output logic [7:0]           dest_client,
  output logic [1:0]           dest_resource,
  output logic signed [31:0]   result_value,
  output logic                 last
);
  import plm_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RIDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int MEM_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic                func_q;
  logic [7:0]          req_q;
  logic [1:0]          res_q;
  logic signed [31:0]  pay_q;

  logic [PTR_W-1:0]    head  [NUM_RESOURCES];
  logic [PTR_W-1:0]    tail  [NUM_RESOURCES];
  logic [CNT_W-1:0]    count [NUM_RESOURCES];
  logic                busy  [NUM_RESOURCES];

  logic [ENTRY_W-1:0]  mem [MEM_DEPTH];
  logic [ENTRY_W-1:0]  rd_data;

  logic                bad_index;
  logic [RIDX_W-1:0]   idx;
  logic [CNT_W-1:0]    cnt;
  logic                bsy;
  logic [1:0]          err;
  logic                is_err;
  logic [PTR_W-1:0]    head_inc;
  logic [PTR_W-1:0]    tail_inc;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    bad_index = !({1'b0, res_q} < 3'(NUM_RESOURCES));
    idx       = res_q[RIDX_W-1:0];
    cnt       = count[idx];
    bsy       = busy[idx];
    head_inc  = wrap_inc(head[idx]);
    tail_inc  = wrap_inc(tail[idx]);
    waddr     = ADDR_W'(int'(idx) * QUEUE_DEPTH + int'(tail[idx]));
    raddr     = ADDR_W'(int'(idx) * QUEUE_DEPTH + int'(head_inc));
    priority if (bad_index) begin
      err = ERR_BAD_INDEX;
    end else if (!func_q && cnt == CNT_W'(QUEUE_DEPTH)) begin
      err = ERR_FULL;
    end else if (func_q && (!bsy || cnt == '0)) begin
      err = ERR_IDLE_DONE;
    end else begin
      err = ERR_NONE;
    end
    is_err        = (err != ERR_NONE);
    st.has_first  = is_err || func_q || !bsy;
    st.has_second = !is_err && func_q && (cnt != CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      req_q  <= requester;
      res_q  <= resource_index;
      pay_q  <= payload;
    end
  end

  // Queue bookkeeping; a request to a free resource is dispatched at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
        busy[i]  <= 1'b0;
      end
    end else if (cmd.exec && !is_err) begin
      if (!func_q) begin
        tail[idx]  <= tail_inc;
        count[idx] <= cnt + CNT_W'(1);
        busy[idx]  <= 1'b1;
      end else begin
        head[idx]  <= head_inc;
        count[idx] <= cnt - CNT_W'(1);
        busy[idx]  <= (cnt != CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !is_err && !func_q) begin
      mem[waddr] <= {req_q, pay_q};
    end
    if (cmd.exec && !is_err && func_q) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      dest_client <= req_q;
      if (is_err) begin
        kind          <= KIND_ERROR;
        error_code    <= err;
        dest_resource <= '0;
        result_value  <= '0;
        last          <= 1'b1;
      end else if (func_q) begin
        kind          <= KIND_REPLY;
        error_code    <= ERR_NONE;
        dest_resource <= '0;
        result_value  <= pay_q;
        last          <= (cnt == CNT_W'(1));
      end else begin
        kind          <= KIND_DISPATCH;
        error_code    <= ERR_NONE;
        dest_resource <= res_q;
        result_value  <= pay_q;
        last          <= 1'b1;
      end
    end else if (cmd.load_second) begin
      kind          <= KIND_DISPATCH;
      error_code    <= ERR_NONE;
      dest_client   <= rd_data[ENTRY_W-1:VALUE_W];
      dest_resource <= res_q;
      result_value  <= signed'(rd_data[VALUE_W-1:0]);
      last          <= 1'b1;
    end
  end

endmodule

>>> hdl/plm_controller.sv
// Sequencer for request capture, evaluation and result delivery.
module plm_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output plm_pkg::plm_cmd_t    cmd,
  input  plm_pkg::plm_status_t st
);
  import plm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PEND
  } state_t;

  state_t state;

  // Take a new request when idle, once the result register is free or draining.
  assign in_ready        = !rst && (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.capture     = in_valid && in_ready;
  assign cmd.exec        = (state == S_EXEC);
  assign cmd.load_second = (state == S_PEND) && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (in_valid && in_ready) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid <= st.has_first;
          state     <= st.has_second ? S_PEND : S_IDLE;
        end
        S_PEND: begin
          // hold the reply until taken, then advance to the dispatch
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("accepted request did not start evaluation");

  a_exec_reg_free: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> !out_valid)
    else $error("result register occupied during evaluation");

  a_pend_has_reply: assert property (@(posedge clk) disable iff (rst)
    state == S_PEND |-> out_valid)
    else $error("second result pending without a first one shown");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && st.has_second |-> st.has_first)
    else $error("dispatch without a preceding reply");

endmodule

>>> bench/per_resource_fifo_lock_manager_tb.sv
// Self-checking testbench for the per-resource FIFO lock manager.
`timescale 1ns / 1ps

module per_resource_fifo_lock_manager_tb;
  import plm_pkg::*;

  localparam int NUM_RES     = 3;
  localparam int DEPTH       = 16;
  localparam int HOLD_CYCLES = 250;
  localparam int TAIL_CYCLES = 20;
  localparam int CHUNKS      = 11;
  localparam int CHUNK_ITEMS = 50;

  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_DONE    = 1'b1;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [7:0]  client;
    logic [1:0]  res;
    logic [31:0] value;
    logic        last;
  } lock_result_t;

  class lock_scoreboard;
    lock_result_t due_results[$];
    logic [7:0]   slot_client [NUM_RES][DEPTH];
    logic [31:0]  slot_value  [NUM_RES][DEPTH];
    int unsigned  q_head  [NUM_RES];
    int unsigned  q_tail  [NUM_RES];
    int unsigned  q_count [NUM_RES];
    bit           res_busy[NUM_RES];
    int           mismatches;

    function new();
      foreach (q_head[i]) begin
        q_head[i]   = 0;
        q_tail[i]   = 0;
        q_count[i]  = 0;
        res_busy[i] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void push_result(logic [1:0] k, logic [1:0] e, logic [7:0] c, logic [1:0] r,
                              logic [31:0] v, logic l);
      lock_result_t x;
      x.kind   = k;
      x.err    = e;
      x.client = c;
      x.res    = r;
      x.value  = v;
      x.last   = l;
      due_results.push_back(x);
    endfunction

    // Work out the results one accepted request causes and advance the queues.
    function void note_request(logic fn, logic [7:0] who, logic [1:0] r, logic [31:0] val);
      int ri;
      ri = r;
      if (ri >= NUM_RES) begin
        push_result(KIND_ERROR, ERR_BAD_INDEX, who, 2'd0, 32'd0, 1'b1);
        return;
      end
      if (fn == FUNC_REQUEST) begin
        if (q_count[ri] >= DEPTH) begin
          push_result(KIND_ERROR, ERR_FULL, who, 2'd0, 32'd0, 1'b1);
          return;
        end
        slot_client[ri][q_tail[ri]] = who;
        slot_value[ri][q_tail[ri]]  = val;
        q_tail[ri]  = (q_tail[ri] + 1) % DEPTH;
        q_count[ri] = q_count[ri] + 1;
      end else begin
        if (!res_busy[ri] || q_count[ri] == 0) begin
          push_result(KIND_ERROR, ERR_IDLE_DONE, who, 2'd0, 32'd0, 1'b1);
          return;
        end
        q_head[ri]   = (q_head[ri] + 1) % DEPTH;
        q_count[ri]  = q_count[ri] - 1;
        res_busy[ri] = 1'b0;
        // the reply is last only when nothing is left to dispatch
        push_result(KIND_REPLY, ERR_NONE, who, 2'd0, val, q_count[ri] == 0);
      end
      if (!res_busy[ri] && q_count[ri] != 0) begin
        push_result(KIND_DISPATCH, ERR_NONE, slot_client[ri][q_head[ri]], r,
                    slot_value[ri][q_head[ri]], 1'b1);
        res_busy[ri] = 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(lock_result_t got);
      lock_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d client 0x%0h",
                 $time, got.kind, got.client);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare_field("kind",          want.kind,   got.kind);
      compare_field("error_code",    want.err,    got.err);
      compare_field("dest_client",   want.client, got.client);
      compare_field("dest_resource", want.res,    got.res);
      compare_field("result_value",  want.value,  got.value);
      compare_field("last",          want.last,   got.last);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = 1'b0;
  logic [7:0]         requester = 8'd0;
  logic [1:0]         resource_index = 2'd0;
  logic signed [31:0] payload = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic [1:0]         error_code;
  logic [7:0]         dest_client;
  logic [1:0]         dest_resource;
  logic signed [31:0] result_value;
  logic               last;

  lock_scoreboard sb;
  bit             calm = 1'b0;
  bit             hold_req = 1'b0;

  per_resource_fifo_lock_manager #(
    .NUM_RESOURCES(NUM_RES),
    .QUEUE_DEPTH  (DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .requester     (requester),
    .resource_index(resource_index),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .error_code    (error_code),
    .dest_client   (dest_client),
    .dest_resource (dest_resource),
    .result_value  (result_value),
    .last          (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(logic fn, logic [7:0] who, logic [1:0] r, logic [31:0] val);
    in_valid       <= 1'b1;
    func           <= fn;
    requester      <= who;
    resource_index <= r;
    payload        <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_request(fn, who, r, val);
  endtask

  task automatic idle_input(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Steer most completions to a busy resource so replies and dispatches dominate.
  task automatic send_random(int req_weight);
    logic       fn;
    logic [1:0] r;
    int         busy_list[$];
    if ($urandom_range(0, 99) < 8) r = 2'd3;
    else r = 2'($urandom_range(0, NUM_RES - 1));
    fn = ($urandom_range(0, 99) < req_weight) ? FUNC_REQUEST : FUNC_DONE;
    if (fn == FUNC_DONE && $urandom_range(0, 9) != 0) begin
      for (int i = 0; i < NUM_RES; i++)
        if (sb.res_busy[i]) busy_list.push_back(i);
      if (busy_list.size() != 0)
        r = 2'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
    end
    send_request(fn, 8'($urandom_range(0, 255)), r, $urandom);
  endtask

  // Result side: check each accepted result, then decide ready for the next cycle.
  initial begin : receiver
    lock_result_t got;
    int           stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.kind   = kind;
        got.err    = error_code;
        got.client = dest_client;
        got.res    = dest_resource;
        got.value  = result_value;
        got.last   = last;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int weight;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // completion while idle, bad index for both operations
    send_request(FUNC_DONE,    8'h00, 2'd0, 32'h0000_0000);
    send_request(FUNC_REQUEST, 8'hFF, 2'd3, 32'h7FFF_FFFF);
    send_request(FUNC_DONE,    8'h5A, 2'd3, 32'h8000_0000);
    // dispatch, queue behind a busy resource, reply plus dispatch, reply alone
    send_request(FUNC_REQUEST, 8'hFF, 2'd1, 32'h8000_0000);
    idle_input(2);
    send_request(FUNC_REQUEST, 8'h01, 2'd1, 32'h7FFF_FFFF);
    send_request(FUNC_DONE,    8'hAA, 2'd1, 32'hFFFF_FFFF);
    send_request(FUNC_DONE,    8'h55, 2'd1, 32'h0000_0001);
    send_request(FUNC_REQUEST, 8'h00, 2'd2, 32'h0000_0000);
    // fill one queue, then overflow it
    for (int i = 0; i <= DEPTH; i++) begin
      send_request(FUNC_REQUEST, i[7:0], 2'd0, $urandom);
      idle_input(pick_gap());
    end
    wait_for_results();

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      case ($urandom_range(0, 2))
        0: weight = 25;
        1: weight = 50;
        default: weight = 80;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      if (chunk == 3) begin
        // hold the result side off while requests keep coming
        calm     = 1'b0;
        hold_req = 1'b1;
      end
      if (chunk == 6) begin
        calm = 1'b0;
        wait_for_results();
      end
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        send_random(weight);
        if (!calm && chunk != 3) idle_input(pick_gap());
      end
    end

    calm = 1'b1;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hdl/plm_pkg.sv
hdl/plm_datapath.sv
hdl/plm_controller.sv
hdl/per_resource_fifo_lock_manager.sv
bench/per_resource_fifo_lock_manager_tb.sv
